>>> rtl/core/chf_pkg.sv
// ----------------------------------------------------------------------------
// chf_pkg
// Shared types, constants and saturation helper for the Cholesky factor core.
// ----------------------------------------------------------------------------
package chf_pkg;

   localparam int WORD_W     = 32;
   localparam int OUT_IDX_W  = 3;
   localparam int CFG_W      = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;
   localparam int ROOT_STEPS = 32;
   localparam int STEP_W     = 5;

   typedef enum logic {
      OP_ROOT,
      OP_DIV
   } arith_op_type;

   typedef struct packed {
      logic               start;
      arith_op_type       op;
      logic [63:0]        operand;   // radicand, or signed dividend
      logic [WORD_W-1:0]  divisor;   // unsigned, nonzero
   } arith_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [WORD_W-1:0]  result;
   } arith_rsp_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [65:0] v);
      logic signed [65:0] hi_lim;
      logic signed [65:0] lo_lim;
      hi_lim = 66'sd2147483647;
      lo_lim = -66'sd2147483648;
      if (v > hi_lim)
         sat_word = 32'sh7fffffff;
      else if (v < lo_lim)
         sat_word = 32'sh80000000;
      else
         sat_word = v[WORD_W-1:0];
   endfunction

endpackage

>>> rtl/core/chf_arith.sv
// ----------------------------------------------------------------------------
// chf_arith
// Shared iterative unit: bit-serial square root and 64/32 signed division,
// one result bit per cycle, saturating to 32 bits signed.
// ----------------------------------------------------------------------------
module chf_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  chf_pkg::arith_req_type req,
   output chf_pkg::arith_rsp_type rsp
);
   import chf_pkg::*;

   typedef enum logic [1:0] {
      A_IDLE,
      A_ROOT,
      A_DIV
   } astate_type;

   astate_type                state_ff;
   logic [63:0]               x_ff;
   logic [63:0]               res_ff;
   logic [63:0]               bit_ff;
   logic [WORD_W-1:0]         div_ff;
   logic                      neg_ff;
   logic [STEP_W-1:0]         cnt_ff;
   logic                      done_ff;
   logic signed [WORD_W-1:0]  result_ff;

   logic [63:0]  root_t;
   logic         root_ge;
   logic [63:0]  mag;
   logic [32:0]  rem2;
   logic         div_ge;
   logic [32:0]  rem_nx;
   logic [31:0]  quot;
   logic signed [65:0] qext;

   always_comb begin
      root_t  = res_ff + bit_ff;
      root_ge = (x_ff >= root_t);
      mag     = req.operand[63] ? (64'd0 - req.operand) : req.operand;
      rem2    = {x_ff[31:0], res_ff[31]};
      div_ge  = (rem2 >= {1'b0, div_ff});
      rem_nx  = div_ge ? (rem2 - {1'b0, div_ff}) : rem2;
      quot    = {res_ff[30:0], div_ge};
      qext    = neg_ff ? (66'sd0 - $signed({34'd0, quot})) : $signed({34'd0, quot});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            A_IDLE: begin
               if (req.start) begin
                  cnt_ff <= '0;
                  div_ff <= req.divisor;
                  neg_ff <= req.operand[63];
                  if (req.op == OP_ROOT) begin
                     x_ff     <= req.operand;
                     res_ff   <= '0;
                     bit_ff   <= 64'd1 << 62;
                     state_ff <= A_ROOT;
                  end else if (mag[63:32] >= req.divisor) begin
                     // quotient needs more than 32 bits: clamp at once
                     done_ff   <= 1'b1;
                     result_ff <= req.operand[63] ? 32'sh80000000 : 32'sh7fffffff;
                  end else begin
                     x_ff     <= {32'd0, mag[63:32]};
                     res_ff   <= {32'd0, mag[31:0]};
                     state_ff <= A_DIV;
                  end
               end
            end
            A_ROOT: begin
               if (root_ge) begin
                  x_ff   <= x_ff - root_t;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == STEP_W'(ROOT_STEPS - 1)) begin
                  done_ff   <= 1'b1;
                  result_ff <= sat_word($signed({2'b00,
                                  (root_ge ? (res_ff >> 1) + bit_ff : res_ff >> 1)}));
                  state_ff  <= A_IDLE;
               end
            end
            A_DIV: begin
               x_ff   <= {32'd0, rem_nx[31:0]};
               res_ff <= {32'd0, quot};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == STEP_W'(ROOT_STEPS - 1)) begin
                  done_ff   <= 1'b1;
                  result_ff <= sat_word(qext);
                  state_ff  <= A_IDLE;
               end
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

>>> rtl/core/cholesky_factorization_top.sv
// ----------------------------------------------------------------------------
// cholesky_factorization_top
// Right-looking Cholesky factorization of an n by n matrix, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Write the order n (1..MAX_ORDER, clamped) on csr_valid/csr_data while idle;
//   csr_ready is always high. It resets to 8.
//   Feed matrix elements row-major, one beat per edge with start high and busy
//   low. The beat that completes n*n elements starts the factorization; busy
//   stays high until all results are out.
//   Results come one per rsp_valid pulse: all n*n entries of L row-major, upper
//   triangle zero, last set on the final one. A nonpositive pivot ends the job
//   with a single beat: status 1, row = col = pivot column, last 1.
//   The receiver cannot stall; each result is shown for one cycle only.
// Arithmetic:
//   One shared root/divide unit serves every operation, one result bit a
//   cycle, and takes one operation at a time. A job needs n roots, one
//   divide per scaled element (n(n-1)/2), one per trailing update (n^3/6
//   roughly) and one emitted result per entry of L.
// Reset clears the load counter, control state and sets n to 8.
// ----------------------------------------------------------------------------
module cholesky_factorization_top #(
   parameter int MAX_ORDER     = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [chf_pkg::WORD_W-1:0]   req_element_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [chf_pkg::CFG_W-1:0]           csr_data,
   output logic                                rsp_valid,
   output logic signed [chf_pkg::WORD_W-1:0]   rsp_factor_value,
   output logic [chf_pkg::OUT_IDX_W-1:0]       rsp_row_index,
   output logic [chf_pkg::OUT_IDX_W-1:0]       rsp_col_index,
   output logic                                rsp_status,
   output logic                                rsp_last
);
   import chf_pkg::*;

   localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW     = $clog2(MAX_ORDER + 1);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      S_LOAD,
      S_PIV_RD,
      S_PIV_CHK,
      S_ROOT,
      S_SC_RD,
      S_SC_DIV,
      S_SC_WT,
      S_UP_RJ,
      S_UP_RK,
      S_UP_MUL,
      S_UP_DIV,
      S_UP_WT,
      S_EM_RD,
      S_EM_PUT
   } state_type;

   state_type                 state_ff;
   logic [CFG_W-1:0]          cfg_ff;
   logic [CNT_W-1:0]          load_cnt_ff;
   logic [NW-1:0]             n_ff;
   logic [NW-1:0]             i_ff;
   logic [NW-1:0]             j_ff;
   logic [NW-1:0]             k_ff;
   logic signed [WORD_W-1:0]  piv_ff;
   logic signed [WORD_W-1:0]  root_ff;
   logic signed [WORD_W-1:0]  aji_ff;
   logic signed [WORD_W-1:0]  ajk_ff;
   logic signed [63:0]        prod_ff;
   arith_req_type             arith_req_ff;
   arith_rsp_type             arith_rsp;

   logic signed [WORD_W-1:0]  mat_mem [DEPTH];
   logic signed [WORD_W-1:0]  l_mem   [DEPTH];
   logic signed [WORD_W-1:0]  mat_rd_ff;
   logic signed [WORD_W-1:0]  l_rd_ff;

   logic                      rsp_valid_ff;
   logic signed [WORD_W-1:0]  rsp_value_ff;
   logic [OUT_IDX_W-1:0]      rsp_row_ff;
   logic [OUT_IDX_W-1:0]      rsp_col_ff;
   logic                      rsp_status_ff;
   logic                      rsp_last_ff;

   logic                      accept;
   logic [NW-1:0]             n_use;
   logic [CNT_W-1:0]          n_sq;
   logic [CNT_W-1:0]          cnt_in;
   logic [NW-1:0]             sel_row;
   logic [NW-1:0]             sel_col;
   logic [2*NW:0]             lin;
   logic [ADDR_W-1:0]         mat_addr;
   logic [ADDR_W-1:0]         mat_wr_addr;
   logic                      mat_we;
   logic signed [WORD_W-1:0]  mat_wdata;
   logic                      l_we;
   logic signed [WORD_W-1:0]  upd_value;
   logic                      emit_last;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_LOAD);

   always_comb begin
      if (cfg_ff == '0)
         n_use = NW'(1);
      else if (cfg_ff > CFG_W'(MAX_ORDER))
         n_use = NW'(MAX_ORDER);
      else
         n_use = NW'(cfg_ff);
      n_sq   = CNT_W'(n_use * n_use);
      cnt_in = load_cnt_ff + 1'b1;
   end

   // row/column of the matrix entry each state touches
   always_comb begin
      case (state_ff)
         S_SC_RD, S_SC_DIV, S_SC_WT, S_UP_RJ: begin
            sel_row = j_ff;
            sel_col = i_ff;
         end
         S_UP_RK: begin
            sel_row = k_ff;
            sel_col = i_ff;
         end
         S_UP_MUL, S_UP_DIV, S_UP_WT, S_EM_RD, S_EM_PUT: begin
            sel_row = j_ff;
            sel_col = k_ff;
         end
         default: begin
            sel_row = i_ff;
            sel_col = i_ff;
         end
      endcase
      lin         = (2*NW+1)'(sel_row * n_ff) + (2*NW+1)'(sel_col);
      mat_addr    = lin[ADDR_W-1:0];
      mat_wr_addr = (state_ff == S_LOAD) ? load_cnt_ff[ADDR_W-1:0] : mat_addr;
      upd_value   = sat_word(66'(ajk_ff) - 66'(arith_rsp.result));
      mat_we      = (state_ff == S_LOAD && accept) || (state_ff == S_UP_WT && arith_rsp.done);
      mat_wdata   = (state_ff == S_LOAD) ? req_element_value : upd_value;
      l_we        = arith_rsp.done && (state_ff == S_ROOT || state_ff == S_SC_WT);
      emit_last   = (j_ff == n_ff - 1'b1) && (k_ff == n_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (mat_we)
         mat_mem[mat_wr_addr] <= mat_wdata;
      mat_rd_ff <= mat_mem[mat_addr];
   end

   always_ff @(posedge clock) begin
      if (l_we)
         l_mem[mat_addr] <= arith_rsp.result;
      l_rd_ff <= l_mem[mat_addr];
   end

   always_ff @(posedge clock) begin
      if (reset)
         cfg_ff <= CFG_RESET;
      else if (csr_valid && csr_ready)
         cfg_ff <= csr_data;
   end

   chf_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (arith_req_ff),
      .rsp   (arith_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_LOAD;
         load_cnt_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
         arith_req_ff.start <= 1'b0;
         n_ff               <= NW'(1);
         i_ff               <= '0;
         j_ff               <= '0;
         k_ff               <= '0;
      end else begin
         rsp_valid_ff       <= 1'b0;
         arith_req_ff.start <= 1'b0;
         case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  if (cnt_in >= n_sq) begin
                     load_cnt_ff <= '0;
                     n_ff        <= n_use;
                     i_ff        <= '0;
                     state_ff    <= S_PIV_RD;
                  end else begin
                     load_cnt_ff <= cnt_in;
                  end
               end
            end
            S_PIV_RD: state_ff <= S_PIV_CHK;
            S_PIV_CHK: begin
               if (mat_rd_ff <= 0) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= '0;
                  rsp_row_ff    <= OUT_IDX_W'(i_ff);
                  rsp_col_ff    <= OUT_IDX_W'(i_ff);
                  rsp_status_ff <= 1'b1;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_LOAD;
               end else begin
                  piv_ff               <= mat_rd_ff;
                  arith_req_ff.start   <= 1'b1;
                  arith_req_ff.op      <= OP_ROOT;
                  arith_req_ff.operand <= {32'd0, mat_rd_ff} << FRACTION_BITS;
                  arith_req_ff.divisor <= '0;
                  state_ff             <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (arith_rsp.done) begin
                  root_ff <= arith_rsp.result;
                  if (i_ff + 1'b1 < n_ff) begin
                     j_ff     <= i_ff + 1'b1;
                     state_ff <= S_SC_RD;
                  end else begin
                     j_ff     <= '0;
                     k_ff     <= '0;
                     state_ff <= S_EM_RD;
                  end
               end
            end
            S_SC_RD: state_ff <= S_SC_DIV;
            S_SC_DIV: begin
               arith_req_ff.start   <= 1'b1;
               arith_req_ff.op      <= OP_DIV;
               arith_req_ff.operand <= 64'(mat_rd_ff) <<< FRACTION_BITS;
               arith_req_ff.divisor <= root_ff;
               state_ff             <= S_SC_WT;
            end
            S_SC_WT: begin
               if (arith_rsp.done) begin
                  if (j_ff + 1'b1 < n_ff) begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= S_SC_RD;
                  end else begin
                     j_ff     <= i_ff + 1'b1;
                     k_ff     <= i_ff + 1'b1;
                     state_ff <= S_UP_RJ;
                  end
               end
            end
            S_UP_RJ: state_ff <= S_UP_RK;
            S_UP_RK: begin
               aji_ff   <= mat_rd_ff;
               state_ff <= S_UP_MUL;
            end
            S_UP_MUL: begin
               prod_ff  <= 64'(aji_ff) * 64'(mat_rd_ff);
               state_ff <= S_UP_DIV;
            end
            S_UP_DIV: begin
               ajk_ff               <= mat_rd_ff;
               arith_req_ff.start   <= 1'b1;
               arith_req_ff.op      <= OP_DIV;
               arith_req_ff.operand <= prod_ff;
               arith_req_ff.divisor <= piv_ff;
               state_ff             <= S_UP_WT;
            end
            S_UP_WT: begin
               if (arith_rsp.done) begin
                  if (k_ff < j_ff) begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_UP_RJ;
                  end else if (j_ff + 1'b1 < n_ff) begin
                     j_ff     <= j_ff + 1'b1;
                     k_ff     <= i_ff + 1'b1;
                     state_ff <= S_UP_RJ;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_PIV_RD;
                  end
               end
            end
            S_EM_RD: state_ff <= S_EM_PUT;
            S_EM_PUT: begin
               rsp_valid_ff  <= 1'b1;
               rsp_value_ff  <= (k_ff > j_ff) ? '0 : l_rd_ff;
               rsp_row_ff    <= OUT_IDX_W'(j_ff);
               rsp_col_ff    <= OUT_IDX_W'(k_ff);
               rsp_status_ff <= 1'b0;
               rsp_last_ff   <= emit_last;
               if (k_ff + 1'b1 < n_ff) begin
                  k_ff <= k_ff + 1'b1;
               end else begin
                  k_ff <= '0;
                  j_ff <= j_ff + 1'b1;
               end
               state_ff <= emit_last ? S_LOAD : S_EM_RD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_factor_value = rsp_value_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_col_index    = rsp_col_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   a_idle_no_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> !arith_rsp.done)
      else $error("arith unit finished while loading");

   a_fail_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> rsp_last)
      else $error("failure beat without last");

   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_col_index > rsp_row_index)) |-> (rsp_factor_value == 0))
      else $error("nonzero upper-triangle beat");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      arith_req_ff.start |-> busy)
      else $error("arith started while idle");

endmodule
